[hw/rtl/ohp_pkg.sv]
package ohp_pkg;

    // Register indexes on the configuration channel.
    localparam logic [2:0] REG_PUMP_REF   = 3'd0;
    localparam logic [2:0] REG_RES_REF    = 3'd1;
    localparam logic [2:0] REG_HEATER_RES = 3'd2;
    localparam logic [2:0] REG_POWER_LIM  = 3'd3;
    localparam logic [2:0] REG_PWM_PERIOD = 3'd4;
    localparam logic [2:0] REG_PROP_GAIN  = 3'd5;
    localparam logic [2:0] REG_INT_GAIN   = 3'd6;
    localparam logic [2:0] REG_DERIV_GAIN = 3'd7;

    // Battery divider scale (36.3 V full scale) in Q16.
    localparam logic [24:0] BAT_SCALE_Q16 = 25'd23789568;
    localparam logic [21:0] UB_RESET_Q16  = 22'd1966080;
    localparam logic [21:0] UB_MIN_Q16    = 22'd65536;
    localparam logic [21:0] UB_MAX_Q16    = 22'd4194303;
    localparam logic [19:0] I_MAX_Q16     = 20'd786432;
    localparam logic [13:0] TEMP_BASE_Q4  = 14'd12560;
    localparam logic [17:0] TEMP_K_Q20    = 18'd143088;

    // Reciprocal of 100 scaled by 2^35, applied to the numerator shifted right by 3.
    localparam logic [31:0] RECIP_100     = 32'd343597383;

    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 48;
    localparam int MUL_W     = 33;

    typedef struct packed {
        logic [15:0] heater_compare;
        logic [14:0] power_cmd;
        logic [14:0] sensor_temp;
        logic [13:0] battery_volts;
        logic [20:0] pump_delta;
        logic [20:0] resistance_delta;
    } ohp_result_t;

endpackage

[hw/rtl/oxygen_sensor_heater_pid_loop_core.sv]
// Heater power loop for a wide-band oxygen sensor.
// Input channel (s_*): one transaction carries a triple of 12-bit converter
// samples. Result channel (m_*): one transaction per input with the PWM
// compare value, heater power, sensor temperature, smoothed battery voltage
// and the smoothed pump and resistance deltas.
// Configuration channel (cfg_*): always ready; write only while idle.
// Each item runs through one registered 33x33 multiplier under a sequencer.
// The four divisions by constants are reciprocal multiplies followed by a
// small remainder correction; only the duty division by the squared battery
// voltage uses the bit-serial divider. The result becomes valid as the
// sequencer returns to idle, and s_tready stays low until then, so a new
// item is taken only once the last one is through.
// The result sits in an output register. The next input is accepted while
// a result waits; if the receiver still stalls when the next result is
// ready, the sequencer holds until the output register is free.
// Reset (aresetn low, synchronous) restores the configuration registers and
// filter state to their defaults and drops m_tvalid.
module oxygen_sensor_heater_pid_loop_core #(
    parameter int ADC_FULL_SCALE = 4096
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // battery_sample, resistance_sample, pump_sample, 4 bits zero fill
    input  logic [39:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // heater_compare, power_cmd, sensor_temp, battery_volts, pump_delta,
    // resistance_delta, 2 bits zero fill
    output logic [103:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import ohp_pkg::*;

    localparam int DIV_V = 10 * ADC_FULL_SCALE;
    // Reciprocal of the battery divisor scaled by 2^37, applied to the
    // numerator shifted right by 5.
    localparam logic [31:0] RECIP_V = 32'((longint'(1) <<< 37) / longint'(DIV_V));

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_LOAD = 5'd1;
    localparam logic [4:0] ST_V    = 5'd2;
    localparam logic [4:0] ST_VM   = 5'd3;
    localparam logic [4:0] ST_VQ   = 5'd4;
    localparam logic [4:0] ST_UB0  = 5'd5;
    localparam logic [4:0] ST_UB1  = 5'd6;
    localparam logic [4:0] ST_UBM  = 5'd7;
    localparam logic [4:0] ST_UBQ  = 5'd8;
    localparam logic [4:0] ST_PF0  = 5'd9;
    localparam logic [4:0] ST_PF1  = 5'd10;
    localparam logic [4:0] ST_PFM  = 5'd11;
    localparam logic [4:0] ST_PFQ  = 5'd12;
    localparam logic [4:0] ST_RF0  = 5'd13;
    localparam logic [4:0] ST_RF1  = 5'd14;
    localparam logic [4:0] ST_RFM  = 5'd15;
    localparam logic [4:0] ST_RFQ  = 5'd16;
    localparam logic [4:0] ST_T0   = 5'd17;
    localparam logic [4:0] ST_T1   = 5'd18;
    localparam logic [4:0] ST_P    = 5'd19;
    localparam logic [4:0] ST_I0   = 5'd20;
    localparam logic [4:0] ST_I1   = 5'd21;
    localparam logic [4:0] ST_I2   = 5'd22;
    localparam logic [4:0] ST_S    = 5'd23;
    localparam logic [4:0] ST_N0   = 5'd24;
    localparam logic [4:0] ST_N1   = 5'd25;
    localparam logic [4:0] ST_N2   = 5'd26;
    localparam logic [4:0] ST_N3   = 5'd27;
    localparam logic [4:0] ST_NW   = 5'd28;

    logic [4:0] state_reg, state_next;

    logic [11:0] pref_reg, rref_reg;
    logic [13:0] hres_reg;
    logic [14:0] plim_reg;
    logic [15:0] period_reg, pg_reg, ig_reg, dg_reg;

    logic [11:0] bs_reg, rs_reg, ps_reg;
    logic [21:0] bf_reg, bf_next;
    logic signed [29:0] pf_reg, pf_next, rf_reg, rf_next, prev_reg, prev_next;
    logic [19:0] integ_reg, integ_next;
    logic [21:0] v_reg, v_next;
    logic        neg_reg, neg_next;
    logic [36:0] dn_reg, dn_next;
    logic signed [45:0] p_reg, p_next;
    logic signed [65:0] lo_reg, lo_next;
    logic [14:0] pw_reg, pw_next;
    logic [14:0] temp_reg, temp_next;
    logic [44:0] num_reg, num_next;

    ohp_result_t res_reg, res_next;
    logic        mvalid_reg, mvalid_next;

    logic signed [MUL_W-1:0]   op_a, op_b;
    logic signed [2*MUL_W-1:0] prod;

    logic                  div_start, div_done;
    logic [DIV_NUM_W-1:0]  div_num, div_quot;
    logic [DIV_DEN_W-1:0]  div_den;

    ohp_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    ohp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Shared arithmetic helpers.
    logic signed [12:0] dp, dr;
    logic signed [39:0] n_pf, n_rf, n_sel, n_mag;
    logic signed [65:0] t_mag, x_val, x_mag, inc, sum, integ_sum;
    logic [33:0]        t_round;
    logic signed [35:0] t_val;
    logic signed [29:0] q_signed;
    logic signed [30:0] e_diff;
    logic [65:0]        pw_wide;
    logic               by_v;
    logic [36:0]        dn_in;
    logic [31:0]        q0, q_fix;
    logic [37:0]        d_val, qd, dq_rem;

    always_comb begin
        dp    = $signed({1'b0, ps_reg}) - $signed({1'b0, pref_reg});
        dr    = $signed({1'b0, rs_reg}) - $signed({1'b0, rref_reg});
        n_pf  = $signed(prod[39:0]) + (40'(dp) <<< 16);
        n_rf  = $signed(prod[39:0]) + (40'(dr) <<< 18) + (40'(dr) <<< 16);
        n_sel = (state_reg == ST_PF1) ? n_pf : n_rf;
        n_mag = n_sel[39] ? -n_sel : n_sel;

        // Dividend for the next division by a constant.
        case (state_reg)
            ST_V:           dn_in = prod[36:0];
            ST_UB1:         dn_in = 37'(prod) + 37'(v_reg) + 37'd50;
            ST_PF1, ST_RF1: dn_in = 37'($unsigned(n_mag)) + 37'd50;
            default:        dn_in = '0;
        endcase

        // The reciprocal product never overshoots and falls short by at
        // most two, so the remainder picks the final quotient.
        by_v   = (state_reg == ST_VQ);
        d_val  = by_v ? 38'(DIV_V) : 38'd100;
        q0     = prod[63:32];
        qd     = by_v ? 38'(q0) * 38'(DIV_V) : 38'(q0) * 38'd100;
        dq_rem = 38'(dn_reg) - qd;
        if (dq_rem >= (d_val << 1)) begin
            q_fix = q0 + 32'd2;
        end else if (dq_rem >= d_val) begin
            q_fix = q0 + 32'd1;
        end else begin
            q_fix = q0;
        end

        q_signed = neg_reg ? -$signed(q_fix[29:0]) : $signed(q_fix[29:0]);

        // Temperature: round away from zero of e * K / 2^32.
        t_mag   = prod[65] ? -prod : prod;
        t_round = 34'((t_mag + 66'sd2147483648) >>> 32);
        t_val   = $signed({22'd0, TEMP_BASE_Q4})
                  - (prod[65] ? -$signed({2'b0, t_round}) : $signed({2'b0, t_round}));

        // Integral increment from the two partial products.
        x_val     = (prod <<< 23) + lo_reg;
        x_mag     = x_val[65] ? -x_val : x_val;
        inc       = (x_mag + 66'sd8388608) >>> 24;
        inc       = x_val[65] ? -inc : inc;
        integ_sum = $signed({46'd0, integ_reg}) + inc;

        e_diff = 31'(rf_reg) - 31'(prev_reg);
        sum    = 66'(p_reg) + ($signed({46'd0, integ_reg}) <<< 12) + prod;
        pw_wide = 66'((sum + 66'sd524288) >>> 20);
    end

    // Multiplier operand selection; the product appears one state later.
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            ST_LOAD: begin
                op_a = MUL_W'($signed({1'b0, bs_reg}));
                op_b = MUL_W'($signed({1'b0, BAT_SCALE_Q16}));
            end
            ST_VM: begin
                op_a = MUL_W'($signed({1'b0, dn_reg[36:5]}));
                op_b = MUL_W'($signed({1'b0, RECIP_V}));
            end
            ST_UB0: begin
                op_a = MUL_W'($signed({1'b0, bf_reg}));
                op_b = MUL_W'(99);
            end
            ST_UBM, ST_PFM, ST_RFM: begin
                op_a = MUL_W'($signed({1'b0, dn_reg[34:3]}));
                op_b = MUL_W'($signed({1'b0, RECIP_100}));
            end
            ST_PF0: begin
                op_a = MUL_W'(pf_reg);
                op_b = MUL_W'(99);
            end
            ST_RF0: begin
                op_a = MUL_W'(rf_reg);
                op_b = MUL_W'(95);
            end
            ST_T0: begin
                op_a = MUL_W'(rf_reg);
                op_b = MUL_W'($signed({1'b0, TEMP_K_Q20}));
            end
            ST_T1: begin
                op_a = MUL_W'(rf_reg);
                op_b = MUL_W'($signed({1'b0, pg_reg}));
            end
            ST_I0: begin
                op_a = MUL_W'($signed({1'b0, p_reg[22:0]}));
                op_b = MUL_W'($signed({1'b0, ig_reg}));
            end
            ST_I1: begin
                op_a = MUL_W'($signed(p_reg[45:23]));
                op_b = MUL_W'($signed({1'b0, ig_reg}));
            end
            ST_I2: begin
                op_a = MUL_W'(e_diff);
                op_b = MUL_W'($signed({1'b0, dg_reg}));
            end
            ST_N0: begin
                op_a = MUL_W'($signed({1'b0, pw_reg}));
                op_b = MUL_W'($signed({1'b0, hres_reg}));
            end
            ST_N1: begin
                op_a = $signed(prod[MUL_W-1:0]);
                op_b = MUL_W'($signed({1'b0, period_reg}));
            end
            ST_N2: begin
                op_a = MUL_W'($signed({1'b0, bf_reg}));
                op_b = MUL_W'($signed({1'b0, bf_reg}));
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        bf_next     = bf_reg;
        pf_next     = pf_reg;
        rf_next     = rf_reg;
        prev_next   = prev_reg;
        integ_next  = integ_reg;
        v_next      = v_reg;
        neg_next    = neg_reg;
        dn_next     = dn_reg;
        p_next      = p_reg;
        lo_next     = lo_reg;
        pw_next     = pw_reg;
        temp_next   = temp_reg;
        num_next    = num_reg;
        res_next    = res_reg;
        mvalid_next = mvalid_reg && !m_tready;
        div_start   = 1'b0;
        div_num     = '0;
        div_den     = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: state_next = ST_V;
            ST_V: begin
                dn_next    = dn_in;
                state_next = ST_VM;
            end
            ST_VM: state_next = ST_VQ;
            ST_VQ: begin
                v_next     = (q_fix > 32'(UB_MAX_Q16)) ? UB_MAX_Q16 : q_fix[21:0];
                state_next = ST_UB0;
            end
            ST_UB0: state_next = ST_UB1;
            ST_UB1: begin
                dn_next    = dn_in;
                state_next = ST_UBM;
            end
            ST_UBM: state_next = ST_UBQ;
            ST_UBQ: begin
                bf_next    = (q_fix < 32'(UB_MIN_Q16)) ? UB_MIN_Q16 : q_fix[21:0];
                state_next = ST_PF0;
            end
            ST_PF0: state_next = ST_PF1;
            ST_RF0: state_next = ST_RF1;
            ST_PF1, ST_RF1: begin
                neg_next   = n_sel[39];
                dn_next    = dn_in;
                state_next = (state_reg == ST_PF1) ? ST_PFM : ST_RFM;
            end
            ST_PFM: state_next = ST_PFQ;
            ST_RFM: state_next = ST_RFQ;
            ST_PFQ: begin
                pf_next    = q_signed;
                state_next = ST_RF0;
            end
            ST_RFQ: begin
                rf_next    = q_signed;
                state_next = ST_T0;
            end
            ST_T0: state_next = ST_T1;
            ST_T1: begin
                if (t_val < 0) begin
                    temp_next = '0;
                end else if (t_val > 36'sd32767) begin
                    temp_next = 15'h7FFF;
                end else begin
                    temp_next = t_val[14:0];
                end
                state_next = ST_P;
            end
            ST_P: begin
                p_next     = prod[45:0];
                state_next = ST_I0;
            end
            ST_I0: state_next = ST_I1;
            ST_I1: begin
                lo_next    = prod;
                state_next = ST_I2;
            end
            ST_I2: begin
                if (integ_sum > $signed({46'd0, I_MAX_Q16})) begin
                    integ_next = I_MAX_Q16;
                end else if (integ_sum < 0) begin
                    integ_next = '0;
                end else begin
                    integ_next = integ_sum[19:0];
                end
                state_next = ST_S;
            end
            ST_S: begin
                prev_next = rf_reg;
                if (sum <= 0) begin
                    pw_next = '0;
                end else if (pw_wide > 66'(plim_reg)) begin
                    pw_next = plim_reg;
                end else begin
                    pw_next = pw_wide[14:0];
                end
                state_next = ST_N0;
            end
            ST_N0: state_next = ST_N1;
            ST_N1: state_next = ST_N2;
            ST_N2: begin
                num_next   = prod[44:0];
                state_next = ST_N3;
            end
            ST_N3: begin
                div_start  = 1'b1;
                div_num    = {3'd0, num_reg, 16'd0};
                div_den    = DIV_DEN_W'(prod[43:0]);
                state_next = ST_NW;
            end
            ST_NW: begin
                if (div_done && (!mvalid_reg || m_tready)) begin
                    res_next.heater_compare   = (div_quot > DIV_NUM_W'(period_reg))
                                                ? period_reg : div_quot[15:0];
                    res_next.power_cmd        = pw_reg;
                    res_next.sensor_temp      = temp_reg;
                    res_next.battery_volts    = bf_reg[21:8];
                    res_next.pump_delta       = pf_reg[28:8];
                    res_next.resistance_delta = rf_reg[28:8];
                    mvalid_next               = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
            pref_reg   <= '0;
            rref_reg   <= '0;
            hres_reg   <= 14'd768;
            plim_reg   <= '0;
            period_reg <= 16'd999;
            pg_reg     <= 16'd410;
            ig_reg     <= 16'd205;
            dg_reg     <= '0;
            bf_reg     <= UB_RESET_Q16;
            pf_reg     <= '0;
            rf_reg     <= '0;
            prev_reg   <= '0;
            integ_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            bf_reg     <= bf_next;
            pf_reg     <= pf_next;
            rf_reg     <= rf_next;
            prev_reg   <= prev_next;
            integ_reg  <= integ_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_PUMP_REF:   pref_reg   <= cfg_data[11:0];
                    REG_RES_REF:    rref_reg   <= cfg_data[11:0];
                    REG_HEATER_RES: hres_reg   <= cfg_data[13:0];
                    REG_POWER_LIM:  plim_reg   <= cfg_data[14:0];
                    REG_PWM_PERIOD: period_reg <= cfg_data;
                    REG_PROP_GAIN:  pg_reg     <= cfg_data;
                    REG_INT_GAIN:   ig_reg     <= cfg_data;
                    REG_DERIV_GAIN: dg_reg     <= cfg_data;
                    default: ;
                endcase
            end
        end
        if (s_tvalid && s_tready) begin
            bs_reg <= s_tdata[11:0];
            rs_reg <= s_tdata[23:12];
            ps_reg <= s_tdata[35:24];
        end
        v_reg    <= v_next;
        neg_reg  <= neg_next;
        dn_reg   <= dn_next;
        p_reg    <= p_next;
        lo_reg   <= lo_next;
        pw_reg   <= pw_next;
        temp_reg <= temp_next;
        num_reg  <= num_next;
        res_reg  <= res_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = {2'b00, res_reg.resistance_delta, res_reg.pump_delta,
                        res_reg.battery_volts, res_reg.sensor_temp,
                        res_reg.power_cmd, res_reg.heater_compare};

endmodule

[hw/rtl/ohp_mul.sv]
module ohp_mul (
    input  logic                                 aclk,
    input  logic signed [ohp_pkg::MUL_W-1:0]     op_a,
    input  logic signed [ohp_pkg::MUL_W-1:0]     op_b,
    output logic signed [2*ohp_pkg::MUL_W-1:0]   prod
);
    import ohp_pkg::*;

    logic signed [2*MUL_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

[hw/rtl/ohp_div.sv]
module ohp_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [ohp_pkg::DIV_NUM_W-1:0]     num,
    input  logic [ohp_pkg::DIV_DEN_W-1:0]     den,
    output logic                              done,
    output logic [ohp_pkg::DIV_NUM_W-1:0]     quot
);
    import ohp_pkg::*;

    logic [DIV_NUM_W-1:0] acc_reg, acc_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [6:0]           cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [DIV_DEN_W:0]   trial;

    // Restoring division, one quotient bit per cycle; quotient bits
    // shift into the numerator register as its bits move into the remainder.
    always_comb begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, acc_reg[DIV_NUM_W-1]};
        if (start) begin
            acc_next  = num;
            rem_next  = '0;
            cnt_next  = 7'(DIV_NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = DIV_DEN_W'(trial - {1'b0, den_reg});
                acc_next = {acc_reg[DIV_NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_DEN_W-1:0];
                acc_next = {acc_reg[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign done = !busy_reg && !start;
    assign quot = acc_reg;

endmodule

[hw/rtl/ohp_checker.sv]
module ohp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);

    // A stalled result must hold.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // An accepted transaction keeps the sequencer busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // Smoothed battery voltage never falls below 1 V.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[59:46] >= 14'd256)
        else $error("battery voltage below floor");

    // No power means no duty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[30:16] == 15'd0 |-> m_tdata[15:0] == 16'd0)
        else $error("compare value without power");

endmodule

bind oxygen_sensor_heater_pid_loop_core ohp_checker u_ohp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/sv/oxygen_sensor_heater_pid_loop_core_checker.sv]
`timescale 1ns / 100ps

module oxygen_sensor_heater_pid_loop_core_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [39:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    output int           mismatches,
    output int           pending
);
    import ohp_pkg::*;

    localparam longint FULL_SCALE = 4096;

    // Register copies.
    logic [11:0] pump_ref, res_ref;
    logic [13:0] heater_res;
    logic [14:0] power_lim;
    logic [15:0] period;
    logic [15:0] kp, ki, kd;

    // Loop state.
    longint unsigned bat_filt;
    longint          pump_filt, res_filt, integ, prev_err;

    ohp_result_t heater_results_q[$];

    function automatic longint round_div(longint n, longint d);
        if (n >= 0) begin
            return (n + d / 2) / d;
        end
        return -((-n + d / 2) / d);
    endfunction

    // Advances the loop state by one sample triple and returns the result.
    function automatic ohp_result_t heater_loop_step(logic [39:0] d);
        longint unsigned v, ub, num, den, cmp, pw;
        longint          e, p, inc, sum, t;
        ohp_result_t     r;
        v = (longint'(d[11:0]) * 23789568) / (10 * FULL_SCALE);
        if (v > 4194303) begin
            v = 4194303;
        end
        ub = (99 * bat_filt + v + 50) / 100;
        if (ub < 65536) begin
            ub = 65536;
        end
        bat_filt = ub;
        pump_filt = round_div(99 * pump_filt
                              + (longint'(d[35:24]) - longint'(pump_ref)) * 65536, 100);
        res_filt = round_div(95 * res_filt
                             + 5 * (longint'(d[23:12]) - longint'(res_ref)) * 65536, 100);
        e = res_filt;
        t = 12560 - round_div(e * 143088, longint'(1) << 32);
        if (t < 0) begin
            t = 0;
        end
        if (t > 32767) begin
            t = 32767;
        end
        p = longint'(kp) * e;
        inc = round_div(longint'(ki) * p, longint'(1) << 24);
        integ = integ + inc;
        if (integ > 786432) begin
            integ = 786432;
        end
        if (integ < 0) begin
            integ = 0;
        end
        sum = p + integ * 4096 + longint'(kd) * (e - prev_err);
        prev_err = e;
        if (sum > 0) begin
            pw = (longint'(sum) + (longint'(1) << 19)) >> 20;
        end else begin
            pw = 0;
        end
        if (pw > power_lim) begin
            pw = power_lim;
        end
        num = pw * heater_res * period * 65536;
        den = ub * ub;
        cmp = num / den;
        if (cmp > period) begin
            cmp = period;
        end
        r.heater_compare   = cmp[15:0];
        r.power_cmd        = pw[14:0];
        r.sensor_temp      = t[14:0];
        r.battery_volts    = ub[21:8];
        r.pump_delta       = 21'(pump_filt >>> 8);
        r.resistance_delta = 21'(res_filt >>> 8);
        return r;
    endfunction

    task automatic report(string field, longint exp_v, longint act_v);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch %s: expected %0d actual %0d", field, exp_v, act_v);
        end
    endtask

    assign pending = heater_results_q.size();

    initial begin
        mismatches = 0;
    end

    always @(posedge aclk) begin
        ohp_result_t exp_r;
        if (!aresetn) begin
            pump_ref = 0;
            res_ref = 0;
            heater_res = 768;
            power_lim = 0;
            period = 999;
            kp = 410;
            ki = 205;
            kd = 0;
            bat_filt = 1966080;
            pump_filt = 0;
            res_filt = 0;
            integ = 0;
            prev_err = 0;
            heater_results_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PUMP_REF:   pump_ref = cfg_data[11:0];
                    REG_RES_REF:    res_ref = cfg_data[11:0];
                    REG_HEATER_RES: heater_res = cfg_data[13:0];
                    REG_POWER_LIM:  power_lim = cfg_data[14:0];
                    REG_PWM_PERIOD: period = cfg_data;
                    REG_PROP_GAIN:  kp = cfg_data;
                    REG_INT_GAIN:   ki = cfg_data;
                    REG_DERIV_GAIN: kd = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (heater_results_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result transaction with no expectation: %h", m_tdata);
                    end
                end else begin
                    exp_r = heater_results_q.pop_front();
                    if (m_tdata[15:0] !== exp_r.heater_compare)
                        report("heater_compare", exp_r.heater_compare, m_tdata[15:0]);
                    if (m_tdata[30:16] !== exp_r.power_cmd)
                        report("power_cmd", exp_r.power_cmd, m_tdata[30:16]);
                    if (m_tdata[45:31] !== exp_r.sensor_temp)
                        report("sensor_temp", exp_r.sensor_temp, m_tdata[45:31]);
                    if (m_tdata[59:46] !== exp_r.battery_volts)
                        report("battery_volts", exp_r.battery_volts, m_tdata[59:46]);
                    if (m_tdata[80:60] !== exp_r.pump_delta)
                        report("pump_delta", $signed(exp_r.pump_delta),
                               $signed(m_tdata[80:60]));
                    if (m_tdata[101:81] !== exp_r.resistance_delta)
                        report("resistance_delta", $signed(exp_r.resistance_delta),
                               $signed(m_tdata[101:81]));
                end
            end
            if (s_tvalid && s_tready) begin
                heater_results_q.push_back(heater_loop_step(s_tdata));
            end
        end
    end

endmodule

[tb/sv/oxygen_sensor_heater_pid_loop_core_test.sv]
`timescale 1ns / 100ps

module oxygen_sensor_heater_pid_loop_core_test;
    import ohp_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [39:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [103:0] m_tdata;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = REG_PUMP_REF;
    logic [15:0]  cfg_data = '0;

    int mismatches;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles = 0;

    oxygen_sensor_heater_pid_loop_core dut (.*);

    oxygen_sensor_heater_pid_loop_core_checker checker_i (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("FAIL oxygen_sensor_heater_pid_loop_core");
        $finish;
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic end_writes();
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_all(logic [15:0] v[8]);
        write_reg(REG_PUMP_REF, v[0]);
        write_reg(REG_RES_REF, v[1]);
        write_reg(REG_HEATER_RES, v[2]);
        write_reg(REG_POWER_LIM, v[3]);
        write_reg(REG_PWM_PERIOD, v[4]);
        write_reg(REG_PROP_GAIN, v[5]);
        write_reg(REG_INT_GAIN, v[6]);
        write_reg(REG_DERIV_GAIN, v[7]);
        end_writes();
    endtask

    // Holds s_tvalid high from one transaction to the next; it only drops during a gap.
    task automatic send_samples(logic [11:0] bat, logic [11:0] res, logic [11:0] pump);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, pump, res, bat};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [11:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 12'd0;
            1: return 12'd4095;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Low-battery stretches pull the smoothed voltage down to its floor.
    task automatic random_items(int count, bit low_battery);
        logic [11:0] bat;
        for (int i = 0; i < count; i++) begin
            bat = low_battery ? 12'($urandom_range(0, 40)) : pick_sample();
            send_samples(bat, pick_sample(), pick_sample());
        end
    endtask

    initial begin
        logic [15:0] regs[8];
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part with the reset gains and full power range.
        write_reg(REG_POWER_LIM, 16'd25600);
        end_writes();
        send_samples(12'd0, 12'd0, 12'd0);
        send_samples(12'd4095, 12'd4095, 12'd4095);
        send_samples(12'd0, 12'd4095, 12'd0);
        send_samples(12'd4095, 12'd0, 12'd4095);
        for (int i = 0; i < 8; i++) send_samples(12'd2048, 12'd4095, 12'd1024);
        send_samples(12'hAAA, 12'h555, 12'hAAA);
        send_samples(12'h555, 12'hAAA, 12'h555);
        drain();
        // References at full scale, every register at an extreme.
        regs = '{16'd4095, 16'd4095, 16'd16383, 16'd32767,
                 16'd65535, 16'd65535, 16'd65535, 16'd65535};
        write_all(regs);
        for (int i = 0; i < 4; i++) send_samples(12'd0, 12'd0, 12'd0);
        for (int i = 0; i < 4; i++) send_samples(12'd4095, 12'd4095, 12'd4095);
        drain();
        // Zero resistance, power limit and period.
        regs = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        write_all(regs);
        for (int i = 0; i < 3; i++) send_samples(12'd4095, 12'd4095, 12'd0);
        drain();

        send_idle_pct = 17;
        recv_idle_pct = 68;
        regs = '{16'd0, 16'd2048, 16'd768, 16'd25600, 16'd999, 16'd410, 16'd205, 16'd100};
        write_all(regs);
        random_items(400, 1'b1);
        drain();

        send_idle_pct = 68;
        recv_idle_pct = 17;
        regs = '{16'd2048, 16'd1024, 16'd16383, 16'd32767,
                 16'd65535, 16'd4096, 16'd65535, 16'd65535};
        write_all(regs);
        random_items(250, 1'b0);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 8; i++) regs[i] = 16'($urandom);
        write_all(regs);
        random_items(200, 1'b0);
        drain();
        regs = '{16'd1000, 16'd2000, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1};
        write_all(regs);
        random_items(150, 1'b0);
        drain();

        repeat (400) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("PASS oxygen_sensor_heater_pid_loop_core");
        end else begin
            $display("FAIL oxygen_sensor_heater_pid_loop_core");
        end
        $finish;
    end

endmodule
